>>> src/sprite_frame_sequencer_top_assert.svh
// Assertion macros used by the checker file of the sprite frame sequencer.
// Needs nothing else; every macro takes a label, a clock and an active-low reset.
`ifndef SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite frame sequencer check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite frame sequencer check failed");

`endif

>>> src/sfs_pkg.sv
// Types, codes and constants of the sprite frame sequencer.
// Used by every module of the block; depends on nothing.
package sfs_pkg;

	localparam int MAX_FRAMES = 16;
	localparam logic [15:0] DEFAULT_DELAY = 16'd6;
	localparam logic [16:0] TICK_MAX = 17'h1FFFF;
	localparam logic [4:0] FRAME_LIMIT = (MAX_FRAMES < 16) ? 5'(MAX_FRAMES) : 5'd16;
	localparam logic [12:0] SHEET_MAX = 13'd4096;
	localparam int DIV_STEPS = 16;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_PLAY      = 3'd1,
		KIND_PAUSE     = 3'd2,
		KIND_STOP      = 3'd3,
		KIND_RESUME    = 3'd4,
		KIND_SET_DELAY = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		REG_FRAME_COUNT  = 3'd0,
		REG_LOOP_ENABLE  = 3'd1,
		REG_LOOP_DELAY   = 3'd2,
		REG_FRAME_WIDTH  = 3'd3,
		REG_FRAME_HEIGHT = 3'd4,
		REG_START_X      = 3'd5,
		REG_START_Y      = 3'd6,
		REG_SHEET_WIDTH  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [4:0]  frame_count;
		logic        loop_enable;
		logic [15:0] loop_delay;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [11:0] start_x;
		logic [11:0] start_y;
		logic [12:0] sheet_width;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [12:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
		logic [12:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [3:0]  frame;
		logic [11:0] rect_x;
		logic [15:0] rect_y;
		logic        running;
		logic        finished;
		logic        write_ok;
	} res_t;

endpackage

>>> src/sfs_regs.sv
// Configuration register file of the sprite frame sequencer.
// Depends on sfs_pkg for the register indexes and the cfg_t bundle.
module sfs_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output sfs_pkg::cfg_t     cfg
);

	sfs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count  <= 5'd1;
			cfg_q.loop_enable  <= 1'b1;
			cfg_q.loop_delay   <= 16'd0;
			cfg_q.frame_width  <= 12'd16;
			cfg_q.frame_height <= 12'd16;
			cfg_q.start_x      <= 12'd0;
			cfg_q.start_y      <= 12'd0;
			cfg_q.sheet_width  <= 13'd256;
		end else if (cfg_valid) begin
			unique case (sfs_pkg::reg_idx_t'(cfg_index))
				sfs_pkg::REG_FRAME_COUNT:  cfg_q.frame_count  <= cfg_data[4:0];
				sfs_pkg::REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_data[0];
				sfs_pkg::REG_LOOP_DELAY:   cfg_q.loop_delay   <= cfg_data;
				sfs_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[11:0];
				sfs_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[11:0];
				sfs_pkg::REG_START_X:      cfg_q.start_x      <= cfg_data[11:0];
				sfs_pkg::REG_START_Y:      cfg_q.start_y      <= cfg_data[11:0];
				sfs_pkg::REG_SHEET_WIDTH:  cfg_q.sheet_width  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/sfs_div.sv
// Restoring divider of the sequencer: one quotient bit per cycle while busy.
// Depends on sfs_pkg for the request and response bundles.
module sfs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sfs_pkg::div_req_t   req,
	output sfs_pkg::div_rsp_t   rsp
);

	logic [15:0] dvd_q;
	logic [12:0] rem_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [12:0] dsr_q;
	logic [13:0] trial;
	logic [13:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[15]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(sfs_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], fits};
			rem_q <= fits ? diff[12:0] : trial[12:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

>>> src/sfs_ctrl.sv
// Sequencer of the sprite frame sequencer: animation state, delay table,
// frame position, scaling and the result register. Uses sfs_pkg and drives sfs_div.
module sfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  sfs_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          kind,
	input  logic [3:0]          delay_index,
	input  logic [15:0]         delay_value,
	output sfs_pkg::div_req_t   div_req,
	input  sfs_pkg::div_rsp_t   div_rsp,
	output logic                out_valid,
	input  logic                out_ready,
	output sfs_pkg::res_t       res
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POS   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_HOLD  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [3:0]    frame_q;
	logic [16:0]   tick_q;
	logic          running_q;
	logic          finished_q;
	logic          ok_q;
	logic [15:0]   delay_q [sfs_pkg::MAX_FRAMES];
	logic [27:0]   prod_q;
	logic          out_valid_q;
	sfs_pkg::res_t res_q;

	logic [4:0]    eff_count;
	logic [3:0]    last_frame;
	logic [12:0]   sheet_w;
	logic [16:0]   tick_inc;
	logic [16:0]   cur_delay;
	logic [16:0]   wrap_at;
	logic [3:0]    frame_d;
	logic [16:0]   tick_d;
	logic          running_d;
	logic          finished_d;
	logic          ok_d;
	logic          accept;
	logic [15:0]   pos;
	logic [28:0]   ry_full;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		if (cfg.frame_count == 5'd0) begin
			eff_count = 5'd1;
		end else if (cfg.frame_count > sfs_pkg::FRAME_LIMIT) begin
			eff_count = sfs_pkg::FRAME_LIMIT;
		end else begin
			eff_count = cfg.frame_count;
		end
		if (cfg.sheet_width == 13'd0) begin
			sheet_w = 13'd1;
		end else if (cfg.sheet_width > sfs_pkg::SHEET_MAX) begin
			sheet_w = sfs_pkg::SHEET_MAX;
		end else begin
			sheet_w = cfg.sheet_width;
		end
	end

	assign last_frame = 4'(eff_count - 5'd1);
	assign tick_inc   = (tick_q == sfs_pkg::TICK_MAX) ? tick_q : tick_q + 17'd1;
	assign cur_delay  = {1'b0, delay_q[frame_q]};
	assign wrap_at    = cur_delay + {1'b0, cfg.loop_delay};

	always_comb begin
		frame_d    = frame_q;
		tick_d     = tick_q;
		running_d  = running_q;
		finished_d = finished_q;
		ok_d       = 1'b1;
		unique case (sfs_pkg::kind_t'(kind))
			sfs_pkg::KIND_TICK: begin
				if (finished_q) begin
					tick_d = '0;
				end else if (running_q) begin
					tick_d = tick_inc;
					if (tick_inc >= cur_delay) begin
						if (frame_q < last_frame) begin
							frame_d = frame_q + 4'd1;
							tick_d  = '0;
						end else if (cfg.loop_enable) begin
							if (cfg.loop_delay == 16'd0 || tick_inc >= wrap_at) begin
								frame_d = '0;
								tick_d  = '0;
							end
						end else begin
							finished_d = 1'b1;
							running_d  = 1'b0;
						end
					end
				end
			end
			sfs_pkg::KIND_PLAY: begin
				frame_d    = '0;
				tick_d     = '0;
				running_d  = 1'b1;
				finished_d = 1'b0;
			end
			sfs_pkg::KIND_PAUSE: running_d = 1'b0;
			sfs_pkg::KIND_STOP: begin
				frame_d    = '0;
				tick_d     = '0;
				running_d  = 1'b0;
				finished_d = 1'b0;
			end
			sfs_pkg::KIND_RESUME: running_d = 1'b1;
			sfs_pkg::KIND_SET_DELAY: ok_d = ({1'b0, delay_index} < eff_count);
			default: ;
		endcase
	end

	assign pos = 16'(frame_q) * 16'(cfg.frame_width) + 16'(cfg.start_x);

	assign div_req.start    = (state_q == ST_POS);
	assign div_req.dividend = pos;
	assign div_req.divisor  = sheet_w;

	assign ry_full = 29'(prod_q) + 29'(cfg.start_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_q     <= '0;
			tick_q      <= '0;
			running_q   <= 1'b1;
			finished_q  <= 1'b0;
			for (int i = 0; i < sfs_pkg::MAX_FRAMES; i++) begin
				delay_q[i] <= sfs_pkg::DEFAULT_DELAY;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						frame_q    <= frame_d;
						tick_q     <= tick_d;
						running_q  <= running_d;
						finished_q <= finished_d;
						if (sfs_pkg::kind_t'(kind) == sfs_pkg::KIND_SET_DELAY && ok_d) begin
							delay_q[delay_index] <= delay_value;
						end
						state_q <= ST_POS;
					end
				end
				ST_POS: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= ok_d;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= 28'(cfg.frame_height) * 28'(div_rsp.quotient);
		end
		if (state_q == ST_HOLD && (!out_valid_q || out_ready)) begin
			res_q.frame    <= frame_q;
			res_q.rect_x   <= div_rsp.remainder[11:0];
			res_q.rect_y   <= (ry_full > 29'd65535) ? 16'hFFFF : ry_full[15:0];
			res_q.running  <= running_q;
			res_q.finished <= finished_q;
			res_q.write_ok <= ok_q;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

>>> src/sprite_frame_sequencer_top.sv
// Sprite animation frame sequencer, top level: ports, register file, sequencer, divider.
// Depends on sfs_pkg, sfs_regs, sfs_ctrl and sfs_div.
//
// Each input beat is one command: tick, play, pause, stop, resume or a delay write.
// Every command yields exactly one output beat with the frame number, the frame's
// rectangle on the sheet, the running and finished flags and a write status.
// Configuration beats write one of eight registers and are taken every cycle;
// they are to be sent only while no command is in flight.
// The output beat becomes valid after the command passes the position, divide,
// scale and hold states, once any held beat is taken; in_ready is low from the
// input beat until the sequencer is idle again, so a new command is taken only after
// the last one is through. A restoring divider splits the frame position by the sheet width.
// The output register holds a finished beat while the next command is taken.
// If the receiver stalls with a beat still held, the sequencer waits at the end
// of the next command and keeps in_ready low until the held beat is taken.
// Reset sets frame 0, playing, not finished, all delays six ticks, configuration at
// its reset values; the result and datapath registers are not reset.
module sprite_frame_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [3:0]  delay_index,
	input  logic [15:0] delay_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_frame,
	output logic [11:0] rect_x,
	output logic [15:0] rect_y,
	output logic        is_running,
	output logic        is_finished,
	output logic        write_ok
);

	sfs_pkg::cfg_t     cfg;
	sfs_pkg::div_req_t div_req;
	sfs_pkg::div_rsp_t div_rsp;
	sfs_pkg::res_t     res;

	sfs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sfs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.delay_index (delay_index),
		.delay_value (delay_value),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign out_frame   = res.frame;
	assign rect_x      = res.rect_x;
	assign rect_y      = res.rect_y;
	assign is_running  = res.running;
	assign is_finished = res.finished;
	assign write_ok    = res.write_ok;

endmodule

>>> src/sfs_checker.sv
// Port-level checks of the sprite frame sequencer, bound to its top level.
// Uses the macros of sprite_frame_sequencer_top_assert.svh.
`include "sprite_frame_sequencer_top_assert.svh"

module sfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  kind,
	input logic [3:0]  delay_index,
	input logic [15:0] delay_value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  out_frame,
	input logic [11:0] rect_x,
	input logic [15:0] rect_y,
	input logic        is_running,
	input logic        is_finished,
	input logic        write_ok
);

	// A command keeps the block busy for the cycle after its beat.
	`SFS_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, in_valid && in_ready, !in_ready)

	// A new result appears only at the end of a command, while input is held off.
	`SFS_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// A stalled result beat keeps its contents.
	`SFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_frame) && $stable(rect_x) && $stable(rect_y) && $stable(is_running) && $stable(is_finished) && $stable(write_ok))

	// A waiting command beat keeps its contents.
	`SFS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(kind) && $stable(delay_index) && $stable(delay_value))

	// Configuration beats are taken at once.
	`SFS_ASSERT_SAME(a_cfg_taken, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (.*);
